[rtl/core/ftrs_pkg.sv]
// ----------------------------------------------------------------------------
// ftrs_pkg: shared types and constants for the flow steering block
// beat layouts, flow entry layout, table geometry and hash constants
// ----------------------------------------------------------------------------
package ftrs_pkg;

   // table geometry; bucket count is a power of two, bucket = crc low bits
   localparam int unsigned BUCKET_COUNT = 1024;
   localparam int unsigned WAY_COUNT    = 4;
   localparam int unsigned ENTRY_COUNT  = BUCKET_COUNT * WAY_COUNT;
   localparam int unsigned BUCKET_AW    = $clog2(BUCKET_COUNT);
   localparam int unsigned ENTRY_AW     = $clog2(ENTRY_COUNT);
   localparam int unsigned WAY_AW       = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;

   // crc32c, reflected, init zero, no final xor
   localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
   localparam int unsigned MSG_W        = 128;
   localparam int unsigned CRC_BYTE_W   = 8;
   localparam int unsigned CRC_STEPS    = MSG_W / CRC_BYTE_W;
   localparam int unsigned CRC_CNT_W    = $clog2(CRC_STEPS);

   typedef struct packed {
      logic [7:0]  protocol;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [15:0] source_port;
      logic [15:0] dest_port;
   } req_type;

   typedef struct packed {
      logic [7:0] worker;
      logic       new_flow;
      logic       table_full;
   } rsp_type;

   // one flow entry as kept in the table memory
   typedef struct packed {
      logic        valid;
      logic [63:0] addr_key;
      logic [39:0] pp_key;
      logic [7:0]  worker;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic        done;
      logic [31:0] crc;
   } crc_result_type;

endpackage

[rtl/core/ftrs_ram.sv]
// ----------------------------------------------------------------------------
// ftrs_ram: generic single-write, single-read memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ftrs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ftrs_crc.sv]
// ----------------------------------------------------------------------------
// ftrs_crc: byte-serial crc32c unit
// folds the 128-bit key message into the crc one byte per cycle
// ----------------------------------------------------------------------------
module ftrs_crc
   import ftrs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [MSG_W-1:0] msg,
   output crc_result_type result
);

   logic [MSG_W-1:0]     msg_ff;
   logic [31:0]          crc_ff;
   logic [CRC_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [31:0]          crc_in;

   // eight bit steps of the reflected crc
   function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                            input logic [CRC_BYTE_W-1:0] data);
      logic [31:0] c;
      c = crc ^ {{(32-CRC_BYTE_W){1'b0}}, data};
      for (int i = 0; i < CRC_BYTE_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   assign crc_in = crc_byte(crc_ff, msg_ff[CRC_BYTE_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // done pulses for one cycle after the last byte
         done_ff <= !start && busy_ff && (cnt_ff == CRC_CNT_W'(CRC_STEPS - 1));
         if (start) begin
            msg_ff  <= msg;
            crc_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            msg_ff <= msg_ff >> CRC_BYTE_W;
            crc_ff <= crc_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CRC_CNT_W'(CRC_STEPS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign result = '{done: done_ff, crc: crc_ff};

endmodule

[rtl/core/ftrs_ctrl.sv]
// ----------------------------------------------------------------------------
// ftrs_ctrl: table sequencer
// clears the table after reset, searches the bucket way by way, inserts
// new flows, keeps the round-robin pointer and the result register
// ----------------------------------------------------------------------------
module ftrs_ctrl
   import ftrs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_accept,
   input  req_type             key,
   input  logic [7:0]          num_workers,
   input  crc_result_type      crc,
   output logic                req_stall,
   output logic                wr_en,
   output logic [ENTRY_AW-1:0] wr_addr,
   output logic [ENTRY_W-1:0]  wr_data,
   output logic [ENTRY_AW-1:0] rd_addr,
   input  logic [ENTRY_W-1:0]  rd_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type           state_ff;
   logic [ENTRY_AW-1:0] clr_addr_ff;
   logic [ENTRY_AW-1:0] base_ff;
   logic [WAY_AW-1:0]   way_ff;
   logic                have_free_ff;
   logic [ENTRY_AW-1:0] free_addr_ff;
   logic [7:0]          next_worker_ff;
   rsp_type             res_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   entry_type           rd_entry;
   entry_type           new_entry;
   logic [ENTRY_AW-1:0] cur_addr;
   logic [ENTRY_AW-1:0] ins_addr;
   logic                hit;
   logic                last_way;
   logic                free_now;
   logic                insert;
   logic [7:0]          nw;
   logic [7:0]          w_sel;
   logic [8:0]          nx_wide;
   logic [7:0]          nx;
   logic                rsp_free;

   always_comb begin
      rd_entry = entry_type'(rd_data);
      cur_addr = base_ff + ENTRY_AW'(way_ff);
      hit      = rd_entry.valid
               && (rd_entry.addr_key == {key.dest_address, key.source_address})
               && (rd_entry.pp_key == {key.protocol, key.dest_port, key.source_port});
      last_way = (way_ff == WAY_AW'(WAY_COUNT - 1));
      free_now = !rd_entry.valid && !have_free_ff;
      ins_addr = have_free_ff ? free_addr_ff : cur_addr;
      insert   = (state_ff == ST_CHECK) && !hit && last_way
               && (have_free_ff || !rd_entry.valid);
      // round robin: zero workers act as one, a stale pointer restarts at 0
      nw       = (num_workers == 8'd0) ? 8'd1 : num_workers;
      w_sel    = (next_worker_ff < nw) ? next_worker_ff : 8'd0;
      nx_wide  = {1'b0, w_sel} + 9'd1;
      nx       = (nx_wide >= {1'b0, nw}) ? 8'd0 : nx_wide[7:0];
      new_entry = '{valid: 1'b1,
                    addr_key: {key.dest_address, key.source_address},
                    pp_key: {key.protocol, key.dest_port, key.source_port},
                    worker: w_sel};
      rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   // clear pass and insertion share the write port
   always_comb begin
      wr_en   = (state_ff == ST_CLEAR) || insert;
      wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : ins_addr;
      wr_data = (state_ff == ST_CLEAR) ? '0 : ENTRY_W'(new_entry);
      rd_addr = cur_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         next_worker_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if ((state_ff == ST_FINISH) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ENTRY_AW'(ENTRY_COUNT - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  state_ff <= ST_HASH;
               end
            end
            ST_HASH: begin
               if (crc.done) begin
                  base_ff      <= ENTRY_AW'(crc.crc[BUCKET_AW-1:0]) * ENTRY_AW'(WAY_COUNT);
                  way_ff       <= '0;
                  have_free_ff <= 1'b0;
                  state_ff     <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (hit) begin
                  res_ff   <= '{worker: rd_entry.worker, new_flow: 1'b0, table_full: 1'b0};
                  state_ff <= ST_FINISH;
               end else begin
                  if (free_now) begin
                     have_free_ff <= 1'b1;
                     free_addr_ff <= cur_addr;
                  end
                  if (last_way) begin
                     if (insert) begin
                        res_ff         <= '{worker: w_sel, new_flow: 1'b1, table_full: 1'b0};
                        next_worker_ff <= nx;
                     end else begin
                        res_ff <= '{worker: 8'd0, new_flow: 1'b0, table_full: 1'b1};
                     end
                     state_ff <= ST_FINISH;
                  end else begin
                     way_ff   <= way_ff + 1'b1;
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_full_means_no_worker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.table_full |-> (rsp_data_ff.worker == 8'd0)
      && !rsp_data_ff.new_flow)
      else $error("full result carries a worker or a new flow");

   a_pointer_moves_on_insert: assert property (@(posedge clock) disable iff (reset)
      !insert |=> $stable(next_worker_ff))
      else $error("round-robin pointer moved without an insertion");

   a_crc_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      crc.done |-> (state_ff == ST_HASH))
      else $error("hash finished outside the hash state");

   a_no_result_during_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff && !wr_data[ENTRY_W-1])
      else $error("result or valid entry written during clear pass");
`endif

endmodule

[rtl/core/flow_table_round_robin_steering_top.sv]
// ----------------------------------------------------------------------------
// flow_table_round_robin_steering_top: exact-match flow table with
// round-robin steering of new flows
// hashes the ipv4 5-tuple with crc32c, searches a 4-way bucket, returns the
// stored worker or inserts the flow and hands out the next worker, or flags table_full
// ----------------------------------------------------------------------------
//
//   channel   ports                          direction   beat
//   request   req_valid req_stall req_data   in          one 5-tuple
//   response  rsp_valid rsp_stall rsp_data   out         worker, new_flow, table_full
//   csr       csr_wr_en csr_wr_data          in          num_workers write
//
// search: byte-serial crc over the 16 message bytes, a state to latch the
//   bucket base, a read and a compare state per way, and a state to load the
//   result register, which waits while the response register is still held
//   by rsp_stall; a hit ends the search early; a new beat is taken only once
//   the result is loaded; the crc unit and the table's single read port set the pace
// reset: synchronous, active high; afterwards a clearing pass writes every
//   table entry (ENTRY_COUNT, 4096) invalid in turn, with req_stall high
// stalls: req_stall is high whenever a beat is in work; the result register
//   lets the next beat enter while a finished response waits on rsp_stall
//
module flow_table_round_robin_steering_top
   import ftrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   // num_workers register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic                req_accept;
   req_type             key_ff;
   logic [7:0]          num_workers_ff;
   logic [MSG_W-1:0]    crc_msg;
   crc_result_type      crc_res;
   logic                wr_en;
   logic [ENTRY_AW-1:0] wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_AW-1:0] rd_addr;
   logic [ENTRY_W-1:0]  rd_data;

   assign req_accept = req_valid && !req_stall;

   // hash words in order: protocol, source, destination, ports
   assign crc_msg = {req_data.dest_port, req_data.source_port,
                     req_data.dest_address, req_data.source_address,
                     24'd0, req_data.protocol};

   // csr register; the user must write it only while idle, the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         num_workers_ff <= 8'd1;
      end else if (csr_wr_en) begin
         num_workers_ff <= csr_wr_data;
      end
   end

   // key held for the compare and insert of the whole search
   always_ff @(posedge clock) begin
      if (req_accept) begin
         key_ff <= req_data;
      end
   end

   ftrs_crc u_crc (
      .clock  (clock),
      .reset  (reset),
      .start  (req_accept),
      .msg    (crc_msg),
      .result (crc_res)
   );

   // flow table: valid bit, both keys and the worker in one word per entry
   ftrs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRY_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ftrs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_accept),
      .key         (key_ff),
      .num_workers (num_workers_ff),
      .crc         (crc_res),
      .req_stall   (req_stall),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
